/* hw/rtl/srat_pkg.sv */
// Shared types and constants for the stream reassembly acknowledgement tracker.
package srat_pkg;

   // One entry of the out-of-order table.
   typedef struct packed {
      logic        valid;
      logic [63:0] offset;
      logic [15:0] length;
      logic        fin;
   } srat_entry_type;

   // Command broadcast to every cell of the table.
   typedef struct packed {
      logic [1:0]     op;
      srat_entry_type entry;
   } srat_cmd_type;

   // Status the table hands back to the controller.
   typedef struct packed {
      srat_entry_type head;
      logic           full;
      logic           dup;
   } srat_stat_type;

   typedef struct packed {
      logic        command;
      logic [63:0] seg_offset;
      logic [15:0] seg_length;
      logic        fin_flag;
      logic [7:0]  path_number;
   } srat_req_type;

   typedef struct packed {
      logic        send_ack;
      logic [63:0] ack_lowest;
      logic [31:0] ack_index_delta;
      logic [31:0] ack_high_delta;
      logic        ack_fin;
      logic        ack_full;
      logic        ack_window;
      logic [7:0]  ack_path;
      logic [3:0]  action;
      logic        data_ready;
      logic        fin_received;
   } srat_rsp_type;

   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_INSERT = 2'd1;
   localparam logic [1:0] CELL_POP    = 2'd2;

   localparam logic [3:0] ACT_CONNECT   = 4'd0;
   localparam logic [3:0] ACT_OBSOLETE  = 4'd1;
   localparam logic [3:0] ACT_INORDER   = 4'd2;
   localparam logic [3:0] ACT_IN_FULL   = 4'd3;
   localparam logic [3:0] ACT_STALE     = 4'd4;
   localparam logic [3:0] ACT_OOO_STORE = 4'd5;
   localparam logic [3:0] ACT_OOO_FULL  = 4'd6;
   localparam logic [3:0] ACT_DUPLICATE = 4'd7;
   localparam logic [3:0] ACT_RELEASE   = 4'd8;

   localparam logic [7:0] REG_RECEIVE_WINDOW  = 8'd0;
   localparam logic [7:0] REG_MAX_PAYLOAD     = 8'd1;
   localparam logic [7:0] REG_PACKET_OVERHEAD = 8'd2;
   localparam logic [7:0] REG_IS_RECEIVER     = 8'd3;

endpackage

/* hw/rtl/stream_reassembly_ack_tracker_core.sv */
// Top level of the stream reassembly acknowledgement tracker.
// A request passes CALC, DECIDE and FINISH before its response is registered; an in-order
// packet also passes DRAIN, which pops each contiguous entry in turn (at most TABLE_DEPTH).
// A new request is held off until the previous one has left FINISH, and a stalled
// response holds the next request off until it is taken.
// Reset is synchronous and active high; it empties the table and clears all counters.
module stream_reassembly_ack_tracker_core #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  srat_pkg::srat_req_type req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output srat_pkg::srat_rsp_type rsp_payload,
   input  logic                  csr_we,
   input  logic [7:0]            csr_index,
   input  logic [31:0]           csr_wdata
);
   import srat_pkg::*;

   // Controller states. A request walks CALC, DECIDE, an optional DRAIN and FINISH.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CALC   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]   state_ff, state_in;
   srat_req_type req_ff;

   // Configuration registers.
   logic [31:0] rwin_ff;
   logic [15:0] maxp_ff;
   logic [7:0]  ovh_ff;
   logic        rcv_ff;

   // Values precomputed in the CALC cycle.
   logic [63:0] end_ff, end_in;
   logic [63:0] endm1_ff, endm1_in;
   logic [32:0] sum_ff, sum_in;
   logic [31:0] limit_ff, limit_in;
   logic [31:0] rel_ff, rel_in;
   logic        dup_ff, dup_in;

   // Architectural state.
   logic [63:0] lp_ff, lp_in;
   logic [63:0] hr_ff, hr_in;
   logic [31:0] buf_ff, buf_in;
   logic        wsent_ff, wsent_in;
   logic        ready_ff, ready_in;
   logic        finseen_ff, finseen_in;
   logic        dfin_ff, dfin_in;

   // Decisions carried into FINISH.
   logic        send_ff, send_in;
   logic        full_ff, full_in;
   logic        use_hr_ff, use_hr_in;
   logic [3:0]  action_ff, action_in;

   logic         rsp_valid_ff, rsp_valid_in;
   srat_rsp_type rsp_ff, rsp_in;

   srat_cmd_type  cmd;
   srat_stat_type stat;

   logic [16:0] size;
   logic [63:0] head_end;
   logic [63:0] acked;

   srat_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Packet size charged against the window: payload plus fixed overhead.
   assign size     = {1'b0, req_ff.seg_length} + {9'b0, ovh_ff};
   assign head_end = stat.head.offset + {48'b0, stat.head.length};
   assign acked    = use_hr_ff ? hr_ff : req_ff.seg_offset;

   always_comb begin
      state_in     = state_ff;
      end_in       = end_ff;
      endm1_in     = endm1_ff;
      sum_in       = sum_ff;
      limit_in     = limit_ff;
      rel_in       = rel_ff;
      dup_in       = dup_ff;
      lp_in        = lp_ff;
      hr_in        = hr_ff;
      buf_in       = buf_ff;
      wsent_in     = wsent_ff;
      ready_in     = ready_ff;
      finseen_in   = finseen_ff;
      dfin_in      = dfin_ff;
      send_in      = send_ff;
      full_in      = full_ff;
      use_hr_in    = use_hr_ff;
      action_in    = action_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      cmd.op          = CELL_HOLD;
      cmd.entry.valid = 1'b1;
      cmd.entry.offset = req_ff.seg_offset;
      cmd.entry.length = req_ff.seg_length;
      cmd.entry.fin    = req_ff.fin_flag;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            end_in   = req_ff.seg_offset + {48'b0, req_ff.seg_length};
            endm1_in = req_ff.seg_offset + {48'b0, req_ff.seg_length} - 64'd1;
            sum_in   = {1'b0, buf_ff} + {16'b0, size};
            limit_in = (rwin_ff >= {16'b0, maxp_ff}) ? (rwin_ff - {16'b0, maxp_ff}) : 32'd0;
            rel_in   = ({15'b0, size} >= buf_ff) ? 32'd0 : (buf_ff - {15'b0, size});
            dup_in   = stat.dup;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            send_in   = 1'b1;
            full_in   = 1'b0;
            use_hr_in = 1'b0;
            state_in  = ST_FINISH;
            if (req_ff.command) begin
               // The reader freed one packet's worth of buffer.
               buf_in  = rel_ff;
               send_in = 1'b0;
               if (rel_ff == 32'd0 && !finseen_ff) begin
                  ready_in = 1'b0;
               end
               action_in = ACT_RELEASE;
            end else if (rcv_ff && req_ff.seg_offset == 64'd0) begin
               lp_in     = end_ff;
               full_in   = 1'b1;
               action_in = ACT_CONNECT;
            end else if (end_ff <= lp_ff && !req_ff.fin_flag) begin
               action_in = ACT_OBSOLETE;
            end else if (req_ff.seg_offset == lp_ff) begin
               if (!req_ff.fin_flag && sum_ff > {1'b0, rwin_ff}) begin
                  full_in   = 1'b1;
                  use_hr_in = 1'b1;
                  action_in = ACT_IN_FULL;
               end else begin
                  if (endm1_ff > hr_ff) begin
                     hr_in = endm1_ff;
                  end
                  if (stat.head.valid && stat.head.offset < end_ff) begin
                     // Overlaps the lowest stored entry: dropped silently.
                     send_in   = 1'b0;
                     action_in = ACT_STALE;
                  end else begin
                     lp_in     = end_ff;
                     dfin_in   = req_ff.fin_flag;
                     action_in = ACT_INORDER;
                     state_in  = ST_DRAIN;
                  end
               end
            end else begin
               if (!req_ff.fin_flag && sum_ff > {1'b0, limit_ff}) begin
                  full_in   = 1'b1;
                  use_hr_in = 1'b1;
                  action_in = ACT_OOO_FULL;
               end else if (dup_ff) begin
                  if (endm1_ff > hr_ff) begin
                     hr_in = endm1_ff;
                  end
                  action_in = ACT_DUPLICATE;
               end else if (stat.full) begin
                  // No free cell: answered like a full window.
                  full_in   = 1'b1;
                  use_hr_in = 1'b1;
                  action_in = ACT_OOO_FULL;
               end else begin
                  if (endm1_ff > hr_ff) begin
                     hr_in = endm1_ff;
                  end
                  cmd.op    = CELL_INSERT;
                  buf_in    = sum_ff[32] ? 32'hFFFF_FFFF : sum_ff[31:0];
                  action_in = ACT_OOO_STORE;
               end
            end
         end
         ST_DRAIN: begin
            // Pop the head entry while it starts exactly at the pending offset and
            // extends past it.
            if (stat.head.valid && stat.head.offset == lp_ff && head_end > lp_ff) begin
               cmd.op  = CELL_POP;
               lp_in   = head_end;
               dfin_in = dfin_ff || stat.head.fin;
            end else begin
               buf_in   = sum_ff[32] ? 32'hFFFF_FFFF : sum_ff[31:0];
               ready_in = 1'b1;
               if (dfin_ff) begin
                  finseen_in = 1'b1;
               end
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               rsp_in.send_ack     = send_ff;
               rsp_in.action       = action_ff;
               rsp_in.data_ready   = ready_ff;
               rsp_in.fin_received = finseen_ff;
               if (send_ff) begin
                  rsp_in.ack_lowest      = lp_ff;
                  rsp_in.ack_index_delta = 32'(acked - lp_ff);
                  rsp_in.ack_high_delta  = 32'(hr_ff - lp_ff);
                  rsp_in.ack_fin         = req_ff.fin_flag;
                  rsp_in.ack_full        = full_ff;
                  rsp_in.ack_window      = !wsent_ff;
                  rsp_in.ack_path        = req_ff.path_number;
                  wsent_in               = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         req_ff <= req_payload;
      end
      end_ff    <= end_in;
      endm1_ff  <= endm1_in;
      sum_ff    <= sum_in;
      limit_ff  <= limit_in;
      rel_ff    <= rel_in;
      dup_ff    <= dup_in;
      dfin_ff   <= dfin_in;
      send_ff   <= send_in;
      full_ff   <= full_in;
      use_hr_ff <= use_hr_in;
      action_ff <= action_in;
      rsp_ff    <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         lp_ff        <= '0;
         hr_ff        <= '0;
         buf_ff       <= '0;
         wsent_ff     <= 1'b0;
         ready_ff     <= 1'b0;
         finseen_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rwin_ff      <= 32'd1048576;
         maxp_ff      <= 16'd1400;
         ovh_ff       <= 8'd64;
         rcv_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lp_ff        <= lp_in;
         hr_ff        <= hr_in;
         buf_ff       <= buf_in;
         wsent_ff     <= wsent_in;
         ready_ff     <= ready_in;
         finseen_ff   <= finseen_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_RECEIVE_WINDOW:  rwin_ff <= csr_wdata;
               REG_MAX_PAYLOAD:     maxp_ff <= csr_wdata[15:0];
               REG_PACKET_OVERHEAD: ovh_ff  <= csr_wdata[7:0];
               REG_IS_RECEIVER:     rcv_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

endmodule

/* hw/rtl/srat_cell.sv */
// One cell of the sorted out-of-order table.
module srat_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  srat_pkg::srat_cmd_type   cmd,
   input  logic                    left_take_new,
   input  srat_pkg::srat_entry_type left_entry,
   input  srat_pkg::srat_entry_type right_entry,
   output srat_pkg::srat_entry_type entry,
   output logic                    keep,
   output logic                    match
);
   import srat_pkg::*;

   srat_entry_type ent_ff, ent_in;

   // The cell keeps its entry on insertion when it sorts below the new one.
   assign keep  = ent_ff.valid && (ent_ff.offset < cmd.entry.offset);
   assign match = ent_ff.valid && (ent_ff.offset == cmd.entry.offset);
   assign entry = ent_ff;

   always_comb begin
      ent_in = ent_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (!keep) begin
               ent_in = left_take_new ? cmd.entry : left_entry;
            end
         end
         CELL_POP: ent_in = right_entry;
         default: ent_in = ent_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      ent_ff.offset <= ent_in.offset;
      ent_ff.length <= ent_in.length;
      ent_ff.fin    <= ent_in.fin;
      if (reset) begin
         ent_ff.valid <= 1'b0;
      end else begin
         ent_ff.valid <= ent_in.valid;
      end
   end

endmodule

/* hw/rtl/srat_table.sv */
// Row of table cells kept sorted by offset, lowest entry in the first cell.
module srat_table #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  srat_pkg::srat_cmd_type  cmd,
   output srat_pkg::srat_stat_type stat
);
   import srat_pkg::*;

   srat_entry_type             ent   [TABLE_DEPTH];
   srat_entry_type             right [TABLE_DEPTH];
   srat_entry_type             left  [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]     keep;
   logic [TABLE_DEPTH-1:0]     take_new;
   logic [TABLE_DEPTH-1:0]     match;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign take_new[i] = 1'b1;
         assign left[i]     = '0;
      end else begin : g_rest
         assign take_new[i] = keep[i-1];
         assign left[i]     = ent[i-1];
      end
      if (i == TABLE_DEPTH - 1) begin : g_last
         assign right[i] = '0;
      end else begin : g_mid
         assign right[i] = ent[i+1];
      end
      srat_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .cmd           (cmd),
         .left_take_new (take_new[i]),
         .left_entry    (left[i]),
         .right_entry   (right[i]),
         .entry         (ent[i]),
         .keep          (keep[i]),
         .match         (match[i])
      );
   end

   assign stat.head = ent[0];
   assign stat.full = ent[TABLE_DEPTH-1].valid;
   assign stat.dup  = |match;

endmodule
